FILE: src/sbmt_pkg.sv
// shared constants, opcode, status and sequencer state types for the
// sorted beat marker table; no dependencies
package sbmt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int FRAME_BITS  = 31;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 32;
  localparam int STEP_W      = 12;
  localparam int RES_W       = 33;
  localparam int SR_W        = 18;
  localparam int SR_RESET    = 44100;
  localparam int WORD_W      = FRAME_BITS + 1;
  localparam int IN_W        = 80;
  localparam int OUT_W       = 48;
  localparam int CMP_W       = RES_W + 2;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_MOVE    = 3'd3,
    OP_NTH     = 3'd4,
    OP_CLOSEST = 3'd5,
    OP_RANGE   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_APP_CHK,
    S_LB_RD,
    S_LB_CHK,
    S_INS_DEC,
    S_SHU_RD,
    S_SHU_WR,
    S_INS_WR,
    S_RM_RD,
    S_RM_CHK,
    S_SHD_RD,
    S_SHD_WR,
    S_RM_END,
    S_WALK_RD,
    S_WALK_CHK,
    S_WALK_END,
    S_CLOSE,
    S_FIN
  } state_e;

  // sample position to frame (frame size of two samples)
  function automatic logic [FRAME_BITS-1:0] to_frame(input logic [POS_W-1:0] pos);
    return pos[FRAME_BITS:1];
  endfunction

endpackage

FILE: src/sorted_beat_marker_table_top.sv
// sorted beat marker table: top level, sequencer and datapath
// depends on sbmt_pkg and sbmt_ram
//
// channel   | dir | fields (lsb first)
// ----------+-----+--------------------------------------------------------------
// s_axis    | in  | opcode 3, position 32, second_position 32, step_count 12,
//           |     | beat_enabled_in 1
// m_axis    | out | result_position 33, found 1, in_range 1, status 2,
//           |     | beat_count 11
// cfg       | in  | sample_rate 18, written when cfg_we_i is high
//
// one word at a time; the table lives in a single ram with one read and one
// write port, and the sequencer touches one entry at a time
// append checks only the last entry, while insert, remove, move, nth and
// closest scan the table; all of them are paced by the single ram read port
// and the shared comparator
// no clearing pass after reset: only entries below the entry count are read
// a finished word waits in the output register; the next word is taken
// meanwhile, and its result waits until the output register is free
module sorted_beat_marker_table_top
  import sbmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SR_W-1:0]  cfg_wdata_i,     // sample_rate
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // opcode, position, second_position, step_count, beat_enabled_in
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // result_position, found, in_range, status, beat_count
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  state_e state_q, state_d;

  logic [SR_W-1:0]       sr_q;
  op_e                   op_q, op_d;
  logic [POS_W-1:0]      pos_q, pos_d, pos2_q, pos2_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  en_in_q, en_in_d;
  logic [FRAME_BITS-1:0] key_q, key_d;      // frame the scan compares against
  logic                  en_q, en_d;        // enable bit of the beat to insert
  logic [CNT_W-1:0]      cnt_q, cnt_d;      // entries in the table
  logic [CNT_W-1:0]      i_q, i_d;          // scan / write index
  logic [CNT_W-1:0]      j_q, j_d;          // removal read index
  logic [CNT_W-1:0]      k_q, k_d;          // shift index for insert
  logic                  hit_q, hit_d;      // lower bound landed on equal frame
  logic                  upper_q, upper_d;  // bound search for first frame above key
  logic                  dir_q, dir_d;      // walk backward
  logic                  phase_q, phase_d;  // second pass of move or closest
  logic [STEP_W-1:0]     mag_q, mag_d;      // enabled beats still to count
  logic [RES_W-1:0]      srch_q, srch_d;    // walk result
  logic [RES_W-1:0]      nx_q, nx_d;        // next beat for closest
  logic [RES_W-1:0]      res_q, res_d;
  logic                  inr_q, inr_d;
  status_e               status_q, status_d;

  logic                  out_valid_q;
  logic [RES_W-1:0]      out_res_q;
  logic                  out_found_q;
  logic                  out_inr_q;
  logic [1:0]            out_status_q;
  logic [CNT_W-1:0]      out_cnt_q;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  logic                  in_acc, out_load;
  logic [FRAME_BITS-1:0] rd_frame;
  logic                  rd_en, cmp_lt, cmp_eq;
  logic                  full, tbl_ok, is_search, lb_end, lb_stop, walk_fail;
  logic                  close_prev;
  logic [CMP_W-1:0]      d_ext, nx_ext, pv_ext;
  state_e                lb_route;

  // word layout: frame above, enable bit at bit 0
  sbmt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i);

  // shared comparator on the entry just read
  assign rd_frame = ram_rdata[WORD_W-1:1];
  assign rd_en    = ram_rdata[0];
  assign cmp_lt   = rd_frame < key_q;
  assign cmp_eq   = rd_frame == key_q;

  assign full      = cnt_q == CNT_W'(TABLE_DEPTH);
  assign tbl_ok    = (sr_q != '0) && (cnt_q != '0);
  assign is_search = (op_q == OP_NTH) || (op_q == OP_CLOSEST) || (op_q == OP_RANGE);
  assign lb_end    = i_q >= cnt_q;
  assign lb_stop   = upper_q ? !(cmp_lt || cmp_eq) : !cmp_lt;
  assign walk_fail = dir_q ? (i_q == '0) : (i_q >= cnt_q);

  // where a bound search goes once it has its index
  always_comb begin
    if (is_search) begin
      lb_route = S_WALK_RD;
    end else if (op_q == OP_REMOVE || (op_q == OP_MOVE && !phase_q)) begin
      lb_route = S_RM_RD;
    end else begin
      lb_route = S_INS_DEC;
    end
  end

  // closest: previous beat wins only when strictly nearer, -1 counts as a beat
  assign d_ext      = CMP_W'(pos_q);
  assign nx_ext     = {{(CMP_W-RES_W){nx_q[RES_W-1]}}, nx_q};
  assign pv_ext     = {{(CMP_W-RES_W){srch_q[RES_W-1]}}, srch_q};
  assign close_prev = $signed(nx_ext - d_ext) > $signed(d_ext - pv_ext);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_START;
      end
      S_START: begin
        case (op_q)
          OP_APPEND: begin
            if (full) state_d = S_FIN;
            else if (cnt_q == '0) state_d = S_INS_WR;
            else state_d = S_APP_CHK;
          end
          OP_INSERT, OP_REMOVE, OP_MOVE: state_d = S_LB_RD;
          OP_NTH: state_d = (!tbl_ok || step_q == '0) ? S_FIN : S_LB_RD;
          OP_CLOSEST: state_d = !tbl_ok ? S_FIN : S_LB_RD;
          OP_RANGE: state_d = (!tbl_ok || pos_q > pos2_q) ? S_FIN : S_LB_RD;
          default: state_d = S_FIN;
        endcase
      end
      // last entry must lie strictly below the new frame
      S_APP_CHK:  state_d = !cmp_lt ? S_FIN : S_INS_WR;
      S_LB_RD:    state_d = lb_end ? lb_route : S_LB_CHK;
      S_LB_CHK:   state_d = lb_stop ? lb_route : S_LB_RD;
      S_INS_DEC:  state_d = (hit_q || full) ? S_FIN : S_SHU_RD;
      S_SHU_RD:   state_d = (k_q == i_q) ? S_INS_WR : S_SHU_WR;
      S_SHU_WR:   state_d = S_SHU_RD;
      S_INS_WR:   state_d = S_FIN;
      S_RM_RD:    state_d = (j_q >= cnt_q) ? S_SHD_RD : S_RM_CHK;
      S_RM_CHK:   state_d = cmp_eq ? S_RM_RD : S_SHD_RD;
      S_SHD_RD:   state_d = (j_q >= cnt_q) ? S_RM_END : S_SHD_WR;
      S_SHD_WR:   state_d = S_SHD_RD;
      S_RM_END:   state_d = (op_q == OP_MOVE) ? S_LB_RD : S_FIN;
      S_WALK_RD:  state_d = walk_fail ? S_WALK_END : S_WALK_CHK;
      S_WALK_CHK: state_d = (rd_en && mag_q == STEP_W'(1)) ? S_WALK_END : S_WALK_RD;
      S_WALK_END: begin
        if (op_q == OP_CLOSEST) state_d = phase_q ? S_CLOSE : S_LB_RD;
        else state_d = S_FIN;
      end
      S_CLOSE:    state_d = S_FIN;
      S_FIN:      state_d = out_load ? S_IDLE : S_FIN;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    op_d     = op_q;
    pos_d    = pos_q;
    pos2_d   = pos2_q;
    step_d   = step_q;
    en_in_d  = en_in_q;
    key_d    = key_q;
    en_d     = en_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    hit_d    = hit_q;
    upper_d  = upper_q;
    dir_d    = dir_q;
    phase_d  = phase_q;
    mag_d    = mag_q;
    srch_d   = srch_q;
    nx_d     = nx_q;
    res_d    = res_q;
    inr_d    = inr_q;
    status_d = status_q;
    ram_we    = 1'b0;
    ram_waddr = i_q[IDX_W-1:0];
    ram_wdata = {key_q, en_q};
    ram_raddr = i_q[IDX_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = op_e'(s_axis_tdata_i[2:0]);
          pos_d   = s_axis_tdata_i[34:3];
          pos2_d  = s_axis_tdata_i[66:35];
          step_d  = s_axis_tdata_i[78:67];
          en_in_d = s_axis_tdata_i[79];
        end
      end
      S_START: begin
        res_d    = '1;
        inr_d    = 1'b0;
        status_d = STAT_DONE;
        phase_d  = 1'b0;
        i_d      = '0;
        upper_d  = 1'b0;
        dir_d    = 1'b0;
        mag_d    = STEP_W'(1);
        en_d     = 1'b1;
        key_d    = to_frame(pos_q);
        case (op_q)
          OP_APPEND: begin
            en_d      = en_in_q;
            i_d       = cnt_q;
            ram_raddr = cnt_q[IDX_W-1:0] - IDX_W'(1);
            if (full) status_d = STAT_FULL;
          end
          OP_INSERT, OP_REMOVE, OP_MOVE: begin
          end
          OP_NTH: begin
            upper_d = step_q[STEP_W-1];
            dir_d   = step_q[STEP_W-1];
            mag_d   = step_q[STEP_W-1] ? (~step_q + STEP_W'(1)) : step_q;
            if (!tbl_ok || step_q == '0) status_d = STAT_IGNORED;
          end
          OP_CLOSEST: begin
            if (!tbl_ok) status_d = STAT_IGNORED;
          end
          OP_RANGE: begin
            if (!tbl_ok || pos_q > pos2_q) status_d = STAT_IGNORED;
          end
          default: status_d = STAT_IGNORED;
        endcase
      end
      S_APP_CHK: begin
        if (!cmp_lt) status_d = STAT_IGNORED;
      end
      S_LB_RD: begin
        j_d = i_q;
        if (lb_end) hit_d = 1'b0;
      end
      S_LB_CHK: begin
        j_d = i_q;
        if (lb_stop) hit_d = cmp_eq;
        else i_d = i_q + CNT_W'(1);
      end
      S_INS_DEC: begin
        k_d = cnt_q;
        if (hit_q) status_d = STAT_IGNORED;
        else if (full) status_d = STAT_FULL;
      end
      S_SHU_RD: begin
        ram_raddr = k_q[IDX_W-1:0] - IDX_W'(1);
      end
      S_SHU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
        k_d       = k_q - CNT_W'(1);
      end
      S_INS_WR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
      end
      S_RM_RD: begin
        ram_raddr = j_q[IDX_W-1:0];
      end
      S_RM_CHK: begin
        if (cmp_eq) begin
          en_d = rd_en;
          j_d  = j_q + CNT_W'(1);
        end
      end
      S_SHD_RD: begin
        ram_raddr = j_q[IDX_W-1:0];
      end
      S_SHD_WR: begin
        // close the gap: entry j moves down to i
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        i_d       = i_q + CNT_W'(1);
        j_d       = j_q + CNT_W'(1);
      end
      S_RM_END: begin
        cnt_d = cnt_q - (j_q - i_q);
        if (op_q == OP_MOVE) begin
          phase_d = 1'b1;
          key_d   = to_frame(pos2_q);
          i_d     = '0;
          upper_d = 1'b0;
        end else if (j_q == i_q) begin
          status_d = STAT_IGNORED;
        end
      end
      S_WALK_RD: begin
        if (walk_fail) srch_d = '1;
        ram_raddr = dir_q ? (i_q[IDX_W-1:0] - IDX_W'(1)) : i_q[IDX_W-1:0];
      end
      S_WALK_CHK: begin
        i_d = dir_q ? (i_q - CNT_W'(1)) : (i_q + CNT_W'(1));
        if (rd_en) begin
          if (mag_q == STEP_W'(1)) srch_d = {1'b0, rd_frame, 1'b0};
          else mag_d = mag_q - STEP_W'(1);
        end
      end
      S_WALK_END: begin
        case (op_q)
          OP_CLOSEST: begin
            if (!phase_q) begin
              nx_d    = srch_q;
              phase_d = 1'b1;
              i_d     = '0;
              upper_d = 1'b1;
              dir_d   = 1'b1;
              mag_d   = STEP_W'(1);
            end
          end
          OP_RANGE: begin
            res_d = srch_q;
            inr_d = !srch_q[RES_W-1] && (srch_q[POS_W-1:0] <= pos2_q);
          end
          default: res_d = srch_q;
        endcase
      end
      S_CLOSE: begin
        res_d = close_prev ? srch_q : nx_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sr_q    <= SR_W'(SR_RESET);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) sr_q <= cfg_wdata_i;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    pos2_q   <= pos2_d;
    step_q   <= step_d;
    en_in_q  <= en_in_d;
    key_q    <= key_d;
    en_q     <= en_d;
    i_q      <= i_d;
    j_q      <= j_d;
    k_q      <= k_d;
    hit_q    <= hit_d;
    upper_q  <= upper_d;
    dir_q    <= dir_d;
    phase_q  <= phase_d;
    mag_q    <= mag_d;
    srch_q   <= srch_d;
    nx_q     <= nx_d;
    res_q    <= res_d;
    inr_q    <= inr_d;
    status_q <= status_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q    <= res_q;
      out_found_q  <= res_q != '1;
      out_inr_q    <= inr_q;
      out_status_q <= status_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_status_q, out_inr_q, out_found_q, out_res_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WR) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("insert did not add one entry");

  a_found_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_found_q == (out_res_q != '1)))
    else $error("found flag disagrees with result position");
`endif

endmodule

FILE: src/sbmt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sbmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
